>>> rtl/tlvrse_pkg.sv
// shared constants, codes and controller/datapath interface types for the tlv record search engine
package tlvrse_pkg;

    localparam int STORE_DEPTH  = 1024;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int FIELD_ADDR_W = 10;
    localparam int BYTE_W       = 8;
    localparam int MAX_LEN      = 256;
    // walk pointer holds any start address and any record advance
    localparam int WALK_SPAN    = (STORE_DEPTH + MAX_LEN > (1 << FIELD_ADDR_W)) ?
                                  (STORE_DEPTH + MAX_LEN) : (1 << FIELD_ADDR_W);
    localparam int WALK_W       = $clog2(WALK_SPAN);
    localparam int HDR_LEN      = 4;

    localparam logic [BYTE_W-1:0] ERASED_BYTE = 8'hFF;

    // stream packing
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int ADDR_LSB    = 0;
    localparam int WDATA_LSB   = ADDR_LSB + FIELD_ADDR_W;
    localparam int MARK_LSB    = WDATA_LSB + BYTE_W;
    localparam int TYPE_LSB    = MARK_LSB + BYTE_W;
    localparam int KEY_LSB     = TYPE_LSB + BYTE_W;
    localparam int CNT_LSB     = KEY_LSB + BYTE_W;
    localparam int S_FIELDS_W  = CNT_LSB + BYTE_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_TUSER_W   = OP_W;
    localparam int M_TDATA_W   = ((FIELD_ADDR_W + 7) / 8) * 8;
    localparam int M_TUSER_W   = STATUS_W;

    // opcodes
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_RECORD = 2'd1;
    localparam logic [OP_W-1:0] OP_VALUE  = 2'd2;
    localparam logic [OP_W-1:0] OP_SPARE  = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] ST_WRITTEN   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_PAST_END  = 2'd3;

    typedef struct packed {
        logic                load;
        logic                rd_en;
        logic                wr_en;
        logic                clr_en;
        logic                next_rec;
        logic                ld_len;
        logic                ld_tok;
        logic                cnt_dec;
        logic                set_res;
        logic [STATUS_W-1:0] res_status;
        logic                res_loc;
        logic                post;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            mark_eq;
        logic            key_eq;
        logic            type_ok;
        logic            rec_out;
        logic            hdr_short;
        logic            pay_out;
        logic            ptr_out;
        logic            cnt_zero;
        logic            clr_last;
        logic            out_free;
    } t_sts;

endpackage

>>> rtl/tlv_record_search_engine.sv
// top level of the tlv record search engine: stream ports, controller and datapath
//
// The engine keeps a 1024-byte record store that reads as erased (0xFF) after reset
// and serves one item at a time. Right after reset it sweeps the store to 0xFF, one byte
// a cycle, and s_axis_tready stays low until the whole store has been swept. All traffic
// goes through the store's one write port and one read port, one byte a cycle: a write
// or an unused opcode is loaded and dispatched and its result is then offered; a record
// search reads the marker, length, type and key of each record header visited in full
// in turn, and a walk that stops on a marker mismatch or a header cut off by the end of
// the store reads only the marker of that last header; a value search fetches and checks
// the bytes examined one by one. The result sits in an output register, so the next
// item can be taken while the previous result still waits for m_axis_tready; the engine
// only stalls if a second result completes before the first one has been transferred.
// Exactly one result transfer follows each input transfer. Status codes: 0 written,
// 1 found, 2 not found, 3 ran past the end of the store; location is the payload start
// of a found record and 0 in every other case.
module tlv_record_search_engine (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // address, write_data, marker, record_type, key_byte, scan_count, zero pad
    input  logic [tlvrse_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // opcode
    input  logic [tlvrse_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // location, zero pad
    output logic [tlvrse_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // status
    output logic [tlvrse_pkg::M_TUSER_W-1:0] m_axis_tuser
);
    import tlvrse_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencer: clearing sweep, dispatch, walk and scan steps, result hand-off
    tlvrse_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // store, walk pointer, comparators and output register
    tlvrse_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_tdata  (s_axis_tdata),
        .i_tuser  (s_axis_tuser),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

endmodule

>>> rtl/tlvrse_dpath.sv
// datapath: byte store, walk pointer, item registers, result and output registers
module tlvrse_dpath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tlvrse_pkg::t_cmd                 i_cmd,
    output tlvrse_pkg::t_sts                 o_sts,
    input  logic [tlvrse_pkg::S_TDATA_W-1:0] i_tdata,
    input  logic [tlvrse_pkg::S_TUSER_W-1:0] i_tuser,
    output logic                             o_tvalid,
    input  logic                             i_tready,
    output logic [tlvrse_pkg::M_TDATA_W-1:0] o_tdata,
    output logic [tlvrse_pkg::M_TUSER_W-1:0] o_tuser
);
    import tlvrse_pkg::*;

    logic [BYTE_W-1:0]       r_store [STORE_DEPTH];
    logic [BYTE_W-1:0]       r_rd_data;
    logic [ADDR_W-1:0]       r_clr_addr;
    logic [WALK_W-1:0]       r_ptr;
    logic [WALK_W-1:0]       r_rec;
    logic [BYTE_W-1:0]       r_len;
    logic                    r_type_ok;
    logic [BYTE_W-1:0]       r_cnt;
    logic [OP_W-1:0]         r_op;
    logic [BYTE_W-1:0]       r_wdata;
    logic [BYTE_W-1:0]       r_mark;
    logic [BYTE_W-1:0]       r_type;
    logic [BYTE_W-1:0]       r_key;
    logic [STATUS_W-1:0]     r_res_status;
    logic [FIELD_ADDR_W-1:0] r_res_loc;
    logic                    r_out_valid;
    logic [STATUS_W-1:0]     r_out_status;
    logic [FIELD_ADDR_W-1:0] r_out_loc;

    logic [WALK_W-1:0]       n_rec;
    logic [WALK_W-1:0]       rec_pay;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_wa;
    logic [BYTE_W-1:0]       mem_wd;
    logic [WALK_W-1:0]       in_addr;

    assign in_addr = WALK_W'(i_tdata[ADDR_LSB +: FIELD_ADDR_W]);
    assign rec_pay = r_rec + WALK_W'(HDR_LEN);
    assign n_rec   = rec_pay + WALK_W'(r_len);

    // store write port: clearing sweep or item write
    always_comb begin
        mem_we = i_cmd.clr_en | i_cmd.wr_en;
        mem_wa = i_cmd.clr_en ? r_clr_addr : r_ptr[ADDR_W-1:0];
        mem_wd = i_cmd.clr_en ? ERASED_BYTE : r_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_store[mem_wa] <= mem_wd;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_store[r_ptr[ADDR_W-1:0]];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_en) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cmd.post) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // walk and item payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ptr   <= in_addr;
            r_rec   <= in_addr;
            r_op    <= i_tuser[OP_W-1:0];
            r_wdata <= i_tdata[WDATA_LSB +: BYTE_W];
            r_mark  <= i_tdata[MARK_LSB +: BYTE_W];
            r_type  <= i_tdata[TYPE_LSB +: BYTE_W];
            r_key   <= i_tdata[KEY_LSB +: BYTE_W];
            r_cnt   <= i_tdata[CNT_LSB +: BYTE_W];
        end else begin
            if (i_cmd.next_rec) begin
                r_ptr <= n_rec;
                r_rec <= n_rec;
            end else if (i_cmd.rd_en) begin
                r_ptr <= r_ptr + WALK_W'(1);
            end
            if (i_cmd.cnt_dec) begin
                r_cnt <= r_cnt - BYTE_W'(1);
            end
        end
        if (i_cmd.ld_len) begin
            r_len <= r_rd_data;
        end
        if (i_cmd.ld_tok) begin
            r_type_ok <= (r_rd_data == r_type);
        end
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_status;
            r_res_loc    <= i_cmd.res_loc ? rec_pay[FIELD_ADDR_W-1:0] : '0;
        end
        if (i_cmd.post) begin
            r_out_status <= r_res_status;
            r_out_loc    <= r_res_loc;
        end
    end

    always_comb begin
        o_sts.op        = r_op;
        o_sts.mark_eq   = (r_rd_data == r_mark);
        o_sts.key_eq    = (r_rd_data == r_key);
        o_sts.type_ok   = r_type_ok;
        o_sts.rec_out   = (r_rec >= WALK_W'(STORE_DEPTH));
        o_sts.hdr_short = (r_rec >= WALK_W'(STORE_DEPTH - 3));
        o_sts.pay_out   = (r_rec >= WALK_W'(STORE_DEPTH - HDR_LEN));
        o_sts.ptr_out   = (r_ptr >= WALK_W'(STORE_DEPTH));
        o_sts.cnt_zero  = (r_cnt == '0);
        o_sts.clr_last  = (r_clr_addr == ADDR_W'(STORE_DEPTH - 1));
        o_sts.out_free  = !r_out_valid || i_tready;
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = M_TDATA_W'(r_out_loc);
    assign o_tuser  = r_out_status;

`ifndef NO_ASSERTIONS
    // only a found record search carries a location
    a_loc_only_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_FOUND)) |-> (r_out_loc == '0))
        else $error("nonzero location on a result other than found");
`endif

endmodule

>>> rtl/tlvrse_ctrl.sv
// controller: sequences the clearing sweep, record walk, value scan and result hand-off
module tlvrse_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  tlvrse_pkg::t_sts i_sts,
    output tlvrse_pkg::t_cmd o_cmd
);
    import tlvrse_pkg::*;

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISPATCH = 4'd2;
    localparam logic [3:0] S_RS_HEAD  = 4'd3;
    localparam logic [3:0] S_RS_TAIL  = 4'd4;
    localparam logic [3:0] S_RS_MARK  = 4'd5;
    localparam logic [3:0] S_RS_LEN   = 4'd6;
    localparam logic [3:0] S_RS_TYPE  = 4'd7;
    localparam logic [3:0] S_RS_KEY   = 4'd8;
    localparam logic [3:0] S_VS_START = 4'd9;
    localparam logic [3:0] S_VS_CMP   = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_sts.op)
                    OP_WRITE: begin
                        o_cmd.set_res = 1'b1;
                        if (i_sts.ptr_out) begin
                            o_cmd.res_status = ST_PAST_END;
                        end else begin
                            o_cmd.wr_en      = 1'b1;
                            o_cmd.res_status = ST_WRITTEN;
                        end
                        n_state = S_DONE;
                    end
                    OP_RECORD: n_state = S_RS_HEAD;
                    OP_VALUE:  n_state = S_VS_START;
                    default: begin
                        o_cmd.set_res    = 1'b1;
                        o_cmd.res_status = ST_NOT_FOUND;
                        n_state          = S_DONE;
                    end
                endcase
            end
            S_RS_HEAD: begin
                if (i_sts.rec_out) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_PAST_END;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = i_sts.hdr_short ? S_RS_TAIL : S_RS_MARK;
                end
            end
            S_RS_TAIL: begin
                o_cmd.set_res    = 1'b1;
                o_cmd.res_status = i_sts.mark_eq ? ST_PAST_END : ST_NOT_FOUND;
                n_state          = S_DONE;
            end
            S_RS_MARK: begin
                if (!i_sts.mark_eq) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_NOT_FOUND;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_RS_LEN;
                end
            end
            S_RS_LEN: begin
                o_cmd.ld_len = 1'b1;
                o_cmd.rd_en  = 1'b1;
                n_state      = S_RS_TYPE;
            end
            S_RS_TYPE: begin
                o_cmd.ld_tok = 1'b1;
                o_cmd.rd_en  = 1'b1;
                n_state      = S_RS_KEY;
            end
            S_RS_KEY: begin
                if (i_sts.type_ok && i_sts.key_eq) begin
                    o_cmd.set_res = 1'b1;
                    if (i_sts.pay_out) begin
                        o_cmd.res_status = ST_PAST_END;
                    end else begin
                        o_cmd.res_status = ST_FOUND;
                        o_cmd.res_loc    = 1'b1;
                    end
                    n_state = S_DONE;
                end else begin
                    o_cmd.next_rec = 1'b1;
                    n_state        = S_RS_HEAD;
                end
            end
            S_VS_START: begin
                if (i_sts.cnt_zero) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_NOT_FOUND;
                    n_state          = S_DONE;
                end else if (i_sts.ptr_out) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_PAST_END;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.cnt_dec = 1'b1;
                    n_state       = S_VS_CMP;
                end
            end
            S_VS_CMP: begin
                // byte read last cycle is checked before the next one is fetched
                if (i_sts.key_eq) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_FOUND;
                    n_state          = S_DONE;
                end else if (i_sts.cnt_zero) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_NOT_FOUND;
                    n_state          = S_DONE;
                end else if (i_sts.ptr_out) begin
                    o_cmd.set_res    = 1'b1;
                    o_cmd.res_status = ST_PAST_END;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.cnt_dec = 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.post = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_post_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.post |-> i_sts.out_free)
        else $error("result posted into an occupied output register");
    a_read_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |-> !i_sts.ptr_out)
        else $error("store read beyond its end");
    a_write_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_en |-> (!i_sts.ptr_out && !o_cmd.clr_en))
        else $error("store write beyond its end or during clearing");
    a_load_goes_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_DISPATCH))
        else $error("accepted item not dispatched");
`endif

endmodule
